// File: rtl/segment_lcd_mux_driver_unit_assert.svh
// ----------------------------------------------------------------------------
// segment_lcd_mux_driver_unit_assert.svh
// assertion macros used by the slcd_drive module
// ----------------------------------------------------------------------------
`ifndef SEGMENT_LCD_MUX_DRIVER_UNIT_ASSERT_SVH
`define SEGMENT_LCD_MUX_DRIVER_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define SLCD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slcd assertion failed");

// next-cycle implication, checked on clk, off while rst_n is low
`define SLCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slcd assertion failed");

`endif

// File: rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types and codes of the segment lcd multiplex driver
// ----------------------------------------------------------------------------
`default_nettype none

package slcd_pkg;

  localparam int SEG_W = 12;

  typedef logic [SEG_W-1:0] slcd_code_t;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BLANK = 2'd1;
  localparam logic [1:0] CMD_DRIVE = 2'd2;

  // common pin drive codes
  localparam logic [1:0] DRV_LOW  = 2'd0;
  localparam logic [1:0] DRV_HIGH = 2'd1;
  localparam logic [1:0] DRV_HALF = 2'd2;

  // one accepted beat leaving the input stage
  typedef struct packed {
    logic wr;
    logic blank;
    logic drive;
  } slcd_ctl_t;

endpackage

`default_nettype wire

// File: rtl/slcd_char_encoder.sv
// ----------------------------------------------------------------------------
// slcd_char_encoder
// maps one ascii byte to its 12-bit segment code, blank outside A-Z and 0-9
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_char_encoder (
  input  wire logic [7:0]         ch,
  output slcd_pkg::slcd_code_t    code
);
  import slcd_pkg::*;

  always_comb begin
    case (ch)
      8'h41: code = 12'hD70;
      8'h42: code = 12'h469;
      8'h43: code = 12'h111;
      8'h44: code = 12'h449;
      8'h45: code = 12'h911;
      8'h46: code = 12'h910;
      8'h47: code = 12'h171;
      8'h48: code = 12'hD70;
      8'h49: code = 12'h009;
      8'h4A: code = 12'h451;
      8'h4B: code = 12'hB12;
      8'h4C: code = 12'h111;
      8'h4D: code = 12'h750;
      8'h4E: code = 12'h552;
      8'h4F: code = 12'h551;
      8'h50: code = 12'hD30;
      8'h51: code = 12'h553;
      8'h52: code = 12'hD32;
      8'h53: code = 12'h961;
      8'h54: code = 12'h008;
      8'h55: code = 12'h551;
      8'h56: code = 12'h390;
      8'h57: code = 12'h5D2;
      8'h58: code = 12'h282;
      8'h59: code = 12'h208;
      8'h5A: code = 12'h281;
      8'h30: code = 12'h6A6;
      8'h31: code = 12'h006;
      8'h32: code = 12'h2E4;
      8'h33: code = 12'h0E6;
      8'h34: code = 12'h446;
      8'h35: code = 12'h4E2;
      8'h36: code = 12'h6E2;
      8'h37: code = 12'h086;
      8'h38: code = 12'h6E6;
      8'h39: code = 12'h4E6;
      default: code = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/slcd_row_store.sv
// ----------------------------------------------------------------------------
// slcd_row_store
// common-row words: merges four character codes on a write beat and
// returns the row of the active common
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_row_store (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire slcd_pkg::slcd_ctl_t  ctl,
  input  wire slcd_pkg::slcd_code_t codes [4],
  input  wire logic [1:0]           active_common,
  output slcd_pkg::slcd_code_t      row_sel
);
  import slcd_pkg::*;

  localparam slcd_code_t ROW0_KEEP = 12'hF2D;

  // bit offset per [position][nibble], nibble 0 is the high nibble
  localparam logic [3:0] PLACE_OFF [4][3] = '{
    '{4'd0, 4'd1, 4'd2},
    '{4'd3, 4'd4, 4'd11},
    '{4'd5, 4'd6, 4'd10},
    '{4'd9, 4'd7, 4'd8}
  };

  slcd_code_t rows_r   [3];
  slcd_code_t rows_nxt [3];
  slcd_code_t placed   [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      placed[r] = '0;
    end
    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < 3; n++) begin
        for (int r = 0; r < 3; r++) begin
          placed[r][PLACE_OFF[p][n]] = placed[r][PLACE_OFF[p][n]] |
                                       codes[p][4*(2-n) + 3 - r];
        end
      end
    end
  end

  always_comb begin
    rows_nxt = rows_r;
    if (ctl.wr) begin
      rows_nxt[0] = (rows_r[0] & ROW0_KEEP) | placed[0];
      rows_nxt[1] = placed[1];
      rows_nxt[2] = placed[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        rows_r[r] <= '0;
      end
    end else begin
      rows_r <= rows_nxt;
    end
  end

  // row 3 is never written and reads as zero
  always_comb begin
    unique case (active_common)
      2'd0:    row_sel = rows_r[0];
      2'd1:    row_sel = rows_r[1];
      2'd2:    row_sel = rows_r[2];
      default: row_sel = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/slcd_drive.sv
// ----------------------------------------------------------------------------
// slcd_drive
// common scan and phase state, forms segment and common levels for a tick
// and holds them in the result register
// ----------------------------------------------------------------------------
`default_nettype none

module slcd_drive (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire slcd_pkg::slcd_ctl_t  ctl,
  input  wire slcd_pkg::slcd_code_t row_sel,
  input  wire logic                 out_stall,
  output logic                      out_free,
  output logic [1:0]                active_common,
  output logic                      out_valid,
  output logic [11:0]               out_segment_lines,
  output logic [1:0]                out_common_zero_drive,
  output logic [1:0]                out_common_one_drive,
  output logic [1:0]                out_common_two_drive,
  output logic [1:0]                out_common_three_drive
);
  import slcd_pkg::*;

  logic        second_phase_r;
  logic [1:0]  active_common_q;
  logic [1:0]  active_common_nxt;
  logic        second_phase_nxt;
  logic        out_valid_r, out_valid_nxt;
  slcd_code_t  seg_r, seg_nxt;
  logic [1:0]  com_r   [4];
  logic [1:0]  com_nxt [4];
  logic        load;

  assign out_free = !out_valid_r || !out_stall;
  assign load     = ctl.blank || ctl.drive;

  always_comb begin
    active_common_nxt = active_common_q;
    second_phase_nxt  = second_phase_r;
    seg_nxt           = seg_r;
    com_nxt           = com_r;
    if (ctl.blank) begin
      seg_nxt = '0;
      for (int k = 0; k < 4; k++) begin
        com_nxt[k] = DRV_LOW;
      end
    end else if (ctl.drive) begin
      for (int k = 0; k < 4; k++) begin
        com_nxt[k] = DRV_HALF;
      end
      if (!second_phase_r) begin
        seg_nxt                  = row_sel;
        com_nxt[active_common_q] = DRV_LOW;
        second_phase_nxt         = 1'b1;
      end else begin
        seg_nxt                  = ~row_sel;
        com_nxt[active_common_q] = DRV_HIGH;
        active_common_nxt        = active_common_q + 2'd1;
        second_phase_nxt         = 1'b0;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_common_q <= '0;
      second_phase_r  <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      active_common_q <= active_common_nxt;
      second_phase_r  <= second_phase_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
    com_r <= com_nxt;
  end

  assign active_common          = active_common_q;
  assign out_valid              = out_valid_r;
  assign out_segment_lines      = seg_r;
  assign out_common_zero_drive  = com_r[0];
  assign out_common_one_drive   = com_r[1];
  assign out_common_two_drive   = com_r[2];
  assign out_common_three_drive = com_r[3];

`include "segment_lcd_mux_driver_unit_assert.svh"

  `SLCD_ASSERT_NEXT(a_first_phase_holds_common,
    ctl.drive && !second_phase_r,
    active_common_q == $past(active_common_q) && second_phase_r)
  `SLCD_ASSERT_NEXT(a_second_phase_advances,
    ctl.drive && second_phase_r,
    active_common_q == $past(active_common_q) + 2'd1 && !second_phase_r)
  `SLCD_ASSERT_NEXT(a_blank_keeps_scan,
    ctl.blank,
    active_common_q == $past(active_common_q) && second_phase_r == $past(second_phase_r))
  `SLCD_ASSERT_NEXT(a_blank_levels,
    ctl.blank,
    seg_r == '0 && com_r[0] == DRV_LOW && com_r[3] == DRV_LOW)

endmodule

`default_nettype wire

// File: rtl/segment_lcd_mux_driver_unit.sv
// ----------------------------------------------------------------------------
// segment_lcd_mux_driver_unit
// four-common, twelve-segment half-bias lcd driver
//
// usage:
//   input channel (in_valid / in_stall) carries a command and four ascii
//   characters. a write beat stores the characters as segment rows and
//   gives no result; a blank tick or a drive tick gives one result beat on
//   the output channel (out_valid / out_stall) with the segment pin levels
//   and the drive of each common (low, high or half supply). command 3 is
//   dropped without a result.
//   an accepted tick passes the input register and then the result
//   register. throughput: one beat per cycle while out_stall holds no
//   result, set by the input register feeding the result register
//   through one pass of table lookup and bit placement.
//   while out_stall holds a result, one more beat waits in the input
//   register and in_stall rises; write beats still pass when no result
//   is waiting behind them.
//   reset: synchronous, rst_n low clears the rows, selects common 0 in its
//   first phase and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_lcd_mux_driver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_char_first,
  input  wire logic [7:0]  in_char_second,
  input  wire logic [7:0]  in_char_third,
  input  wire logic [7:0]  in_char_fourth,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      out_segment_lines,
  output logic [1:0]       out_common_zero_drive,
  output logic [1:0]       out_common_one_drive,
  output logic [1:0]       out_common_two_drive,
  output logic [1:0]       out_common_three_drive
);
  import slcd_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_cmd_r;
  logic [7:0]  s1_char_r [4];
  slcd_code_t  codes [4];
  slcd_code_t  row_sel;
  logic [1:0]  active_common;
  logic        out_free;
  logic        has_result;
  logic        fire;
  logic        in_take;
  slcd_ctl_t   ctl;

  always_comb begin
    ctl        = '0;
    has_result = 1'b0;
    unique case (s1_cmd_r)
      CMD_WRITE: ctl.wr    = 1'b1;
      CMD_BLANK: begin
        ctl.blank  = 1'b1;
        has_result = 1'b1;
      end
      CMD_DRIVE: begin
        ctl.drive  = 1'b1;
        has_result = 1'b1;
      end
      default:   ctl = '0;
    endcase
    fire = s1_valid_r && (!has_result || out_free);
    if (!fire) begin
      ctl = '0;
    end
  end

  assign in_stall = s1_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else begin
      s1_valid_nxt = s1_valid_r && !fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r     <= in_cmd;
      s1_char_r[0] <= in_char_first;
      s1_char_r[1] <= in_char_second;
      s1_char_r[2] <= in_char_third;
      s1_char_r[3] <= in_char_fourth;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_enc
    slcd_char_encoder u_enc (
      .ch   (s1_char_r[g]),
      .code (codes[g])
    );
  end

  slcd_row_store u_rows (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .codes         (codes),
    .active_common (active_common),
    .row_sel       (row_sel)
  );

  slcd_drive u_drive (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .ctl                    (ctl),
    .row_sel                (row_sel),
    .out_stall              (out_stall),
    .out_free               (out_free),
    .active_common          (active_common),
    .out_valid              (out_valid),
    .out_segment_lines      (out_segment_lines),
    .out_common_zero_drive  (out_common_zero_drive),
    .out_common_one_drive   (out_common_one_drive),
    .out_common_two_drive   (out_common_two_drive),
    .out_common_three_drive (out_common_three_drive)
  );

endmodule

`default_nettype wire
